// ----- sv/utp_pkg.sv -----
`timescale 1ns / 1ps
// utp_pkg: shared constants, types and the hex decode for the UUID text parser.
// No dependencies; imported by uuid_text_parser_core and tb_uuid_text_parser_core.
package utp_pkg;

  // Text limits
  localparam int unsigned MaxTextLen     = 36;
  localparam int unsigned GroupMaxDigits = 16;

  // Counter widths and saturation points
  localparam int unsigned CharCntW  = 6;
  localparam int unsigned DashCntW  = 3;
  localparam int unsigned DigitCntW = 5;

  localparam logic [CharCntW-1:0]  CharSat      = 6'd37;
  localparam logic [CharCntW-1:0]  CharLimit    = 6'(MaxTextLen);
  localparam logic [DashCntW-1:0]  DashSat      = 3'd5;
  localparam logic [DashCntW-1:0]  DashExpected = 3'd4;
  localparam logic [DigitCntW-1:0] DigitSat     = 5'd17;
  localparam logic [DigitCntW-1:0] DigitMax     = 5'(GroupMaxDigits);

  // Group slots in the packed words, indexed by dashes seen before the group
  localparam logic [DashCntW-1:0] GroupTimeLow = 3'd0;
  localparam logic [DashCntW-1:0] GroupTimeMid = 3'd1;
  localparam logic [DashCntW-1:0] GroupTimeHi  = 3'd2;
  localparam logic [DashCntW-1:0] GroupClock   = 3'd3;

  localparam int unsigned AccumW = 48;
  localparam int unsigned WordW  = 64;

  // Characters of interest
  localparam logic [7:0] CharDash   = 8'h2d;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharLowA   = 8'h61;
  localparam logic [7:0] CharLowF   = 8'h66;
  localparam logic [7:0] CharUpA    = 8'h41;
  localparam logic [7:0] CharUpF    = 8'h46;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  // Decode one ASCII character as a hex digit
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    logic [7:0] diff;
    r    = '0;
    diff = '0;
    if (c >= CharZero && c <= CharNine) begin
      diff    = c - CharZero;
      r.valid = 1'b1;
      r.value = diff[3:0];
    end else if (c >= CharLowA && c <= CharLowF) begin
      diff    = c - CharLowA + 8'd10;
      r.valid = 1'b1;
      r.value = diff[3:0];
    end else if (c >= CharUpA && c <= CharUpF) begin
      diff    = c - CharUpA + 8'd10;
      r.valid = 1'b1;
      r.value = diff[3:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/uuid_text_parser_core.sv -----
`timescale 1ns / 1ps
// uuid_text_parser_core: streaming parser for the text form of a UUID.
// Depends on utp_pkg for constants, the hex decode and the digit type.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one ASCII character per
//   request in text_char_i; final_char_i marks the last character of a string.
//   Output channel (out_valid_o / out_stall_i) carries one result per string:
//   parse_ok_o plus the 128-bit UUID as uuid_high_o:uuid_low_o (both zero
//   when the string is malformed).
//   Throughput: one character per cycle while in_stall_o is low. Each
//   character updates small counters, the error flag, the packed words and
//   a 48-bit shift accumulator, all in combinational logic ahead of the parse
//   state registers. The output register takes the result in the cycle
//   after the final character is accepted.
//   Stall: the output register holds its result while out_stall_i is high;
//   in_stall_o rises only while that register is full and stalled, so
//   characters keep flowing whenever the result slot is free or draining.
//   Reset: clears the parse state and empties the output register.
//   After each final character the parse state returns to its reset value.
module uuid_text_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // character requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_char_i,
  input  logic        final_char_i,
  // parse results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        parse_ok_o,
  output logic [63:0] uuid_high_o,
  output logic [63:0] uuid_low_o
);
  import utp_pkg::*;

  // Parse state
  logic [CharCntW-1:0]  char_cnt_q, char_cnt_d;
  logic [DashCntW-1:0]  dash_cnt_q, dash_cnt_d;
  logic [DigitCntW-1:0] digit_cnt_q, digit_cnt_d;
  logic                 bad_q, bad_d;
  logic [AccumW-1:0]    accum_q, accum_d;
  logic [WordW-1:0]     high_q, high_d;
  logic [WordW-1:0]     low_q, low_d;

  // Result register
  logic                 out_valid_q, out_valid_d;
  logic                 ok_q, ok_d;
  logic [WordW-1:0]     res_high_q, res_high_d;
  logic [WordW-1:0]     res_low_q, res_low_d;

  logic       accept;
  logic       load_result;
  logic       is_dash;
  hex_digit_t digit;
  logic       group_ok_cur;
  logic       group_ok_nxt;

  // Stall only when a finished result is still held by the receiver
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign load_result = accept & final_char_i;

  assign is_dash = (text_char_i == CharDash);
  assign digit   = hex_decode(text_char_i);

  assign group_ok_cur = (digit_cnt_q != '0) && (digit_cnt_q <= DigitMax);

  // Next parse state for one character
  always_comb begin
    char_cnt_d  = char_cnt_q;
    dash_cnt_d  = dash_cnt_q;
    digit_cnt_d = digit_cnt_q;
    bad_d       = bad_q;
    accum_d     = accum_q;
    high_d      = high_q;
    low_d       = low_q;

    if (char_cnt_q < CharSat) begin
      char_cnt_d = char_cnt_q + 1'b1;
    end

    if (is_dash) begin
      // Close the current group: check its length and drop it in its slot
      if (!group_ok_cur) begin
        bad_d = 1'b1;
      end
      unique case (dash_cnt_q)
        GroupTimeLow: high_d = high_q | {accum_q[31:0], 32'h0};
        GroupTimeMid: high_d = high_q | {32'h0, accum_q[15:0], 16'h0};
        GroupTimeHi:  high_d = high_q | {48'h0, accum_q[15:0]};
        GroupClock:   low_d  = low_q  | {accum_q[15:0], 48'h0};
        default: ;
      endcase
      if (dash_cnt_q < DashSat) begin
        dash_cnt_d = dash_cnt_q + 1'b1;
      end
      digit_cnt_d = '0;
      accum_d     = '0;
    end else if (digit.valid) begin
      if (digit_cnt_q < DigitSat) begin
        digit_cnt_d = digit_cnt_q + 1'b1;
      end
      accum_d = {accum_q[AccumW-5:0], digit.value};
    end else begin
      bad_d = 1'b1;
    end
  end

  assign group_ok_nxt = (digit_cnt_d != '0) && (digit_cnt_d <= DigitMax);

  // Verdict on the string as it stands after this character
  always_comb begin
    ok_d = ~bad_d && (dash_cnt_d == DashExpected) && group_ok_nxt &&
           (char_cnt_d <= CharLimit);
    res_high_d = ok_d ? high_d : '0;
    res_low_d  = ok_d ? (low_d | {16'h0, accum_d}) : '0;
  end

  // Result slot: fill on a final character, empty once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_result) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_cnt_q  <= '0;
      dash_cnt_q  <= '0;
      digit_cnt_q <= '0;
      bad_q       <= 1'b0;
      accum_q     <= '0;
      high_q      <= '0;
      low_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        if (final_char_i) begin
          // String done: drop back to the reset state
          char_cnt_q  <= '0;
          dash_cnt_q  <= '0;
          digit_cnt_q <= '0;
          bad_q       <= 1'b0;
          accum_q     <= '0;
          high_q      <= '0;
          low_q       <= '0;
        end else begin
          char_cnt_q  <= char_cnt_d;
          dash_cnt_q  <= dash_cnt_d;
          digit_cnt_q <= digit_cnt_d;
          bad_q       <= bad_d;
          accum_q     <= accum_d;
          high_q      <= high_d;
          low_q       <= low_d;
        end
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_result) begin
      ok_q       <= ok_d;
      res_high_q <= res_high_d;
      res_low_q  <= res_low_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign parse_ok_o  = ok_q;
  assign uuid_high_o = res_high_q;
  assign uuid_low_o  = res_low_q;

`ifndef NO_ASSERTIONS
  // A malformed string reports all-zero words
  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !parse_ok_o |-> uuid_high_o == '0 && uuid_low_o == '0)
    else $error("malformed result carries nonzero words");

  // A final character yields a result on the next cycle
  a_final_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && final_char_i |=> out_valid_o)
    else $error("final character produced no result");

  // The parse state restarts after each string
  a_state_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && final_char_i |=>
      char_cnt_q == '0 && dash_cnt_q == '0 && digit_cnt_q == '0 && !bad_q)
    else $error("parse state not cleared after final character");

  // Counters never pass their saturation points
  a_counters_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_cnt_q <= CharSat && dash_cnt_q <= DashSat && digit_cnt_q <= DigitSat)
    else $error("parse counter beyond saturation");
`endif

endmodule

// ----- tb/tb_uuid_text_parser_core.sv -----
`timescale 1ns / 1ps
// tb_uuid_text_parser_core: self-checking bench for the streaming UUID text parser.
// Depends on utp_pkg and uuid_text_parser_core; a local parse model predicts each result.
module tb_uuid_text_parser_core;
  import utp_pkg::*;

  localparam int unsigned TextTarget    = 1650;  // minimum characters of text to queue, directed and random
  localparam int unsigned IdlePct       = 35;
  localparam int unsigned HoldOffCycles = 120;   // one long output back-pressure
  localparam int unsigned HoldOffAt     = 10;    // results seen before the hold-off
  localparam int unsigned StuckLimit    = 2000;  // cycles without any handshake
  localparam int unsigned DrainCycles   = 8;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } text_req_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] hi;
    logic [63:0] lo;
  } uuid_res_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [7:0]  text_char_i  = '0;
  logic        final_char_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic        parse_ok_o;
  logic [63:0] uuid_high_o;
  logic [63:0] uuid_low_o;

  text_req_t  char_q[$];      // character requests not yet accepted
  uuid_res_t  uuid_exp_q[$];  // parse results owed by the block
  logic [7:0] text_buf[$];    // string under construction

  int  text_total   = 0;
  int  chars_sent   = 0;
  int  results_seen = 0;
  int  errors       = 0;
  int  stuck_cycles = 0;
  int  hold_left    = 0;
  bit  held_once    = 1'b0;
  bit  char_taken   = 1'b0;
  bit  send_calm;
  bit  recv_calm;

  // Parse state of the local model
  logic [CharCntW-1:0]  seen_chars  = '0;
  logic [DashCntW-1:0]  seen_dashes = '0;
  logic [DigitCntW-1:0] grp_digits  = '0;
  logic                 text_bad    = 1'b0;
  logic [AccumW-1:0]    grp_value   = '0;
  logic [WordW-1:0]     word_hi     = '0;
  logic [WordW-1:0]     word_lo     = '0;

  uuid_text_parser_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_char_i  (text_char_i),
    .final_char_i (final_char_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .parse_ok_o   (parse_ok_o),
    .uuid_high_o  (uuid_high_o),
    .uuid_low_o   (uuid_low_o)
  );

  always #5 clk_i = ~clk_i;

  // No idling on either side for a stretch in the middle of the run
  assign send_calm = (chars_sent >= 500) && (chars_sent < 800);
  assign recv_calm = (results_seen >= 40) && (results_seen < 55);

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= CharZero && c <= CharNine) return int'(c - CharZero);
    if (c >= CharLowA && c <= CharLowF) return int'(c - CharLowA) + 10;
    if (c >= CharUpA && c <= CharUpF) return int'(c - CharUpA) + 10;
    return -1;
  endfunction

  // Absorb one accepted character; on the last one, queue the result and clear
  task automatic parse_char(input logic [7:0] c, input logic is_last);
    int        nib;
    logic      len_ok;
    uuid_res_t r;
    if (seen_chars < CharSat) seen_chars++;
    if (c == CharDash) begin
      if (grp_digits == 0 || grp_digits > DigitMax) text_bad = 1'b1;
      // Close the group into its slot; groups past the fourth dash go nowhere
      case (seen_dashes)
        GroupTimeLow: word_hi[63:32] = word_hi[63:32] | grp_value[31:0];
        GroupTimeMid: word_hi[31:16] = word_hi[31:16] | grp_value[15:0];
        GroupTimeHi:  word_hi[15:0]  = word_hi[15:0]  | grp_value[15:0];
        GroupClock:   word_lo[63:48] = word_lo[63:48] | grp_value[15:0];
        default: ;
      endcase
      if (seen_dashes < DashSat) seen_dashes++;
      grp_digits = '0;
      grp_value  = '0;
    end else begin
      nib = hex_nibble(c);
      if (nib < 0) begin
        text_bad = 1'b1;
      end else begin
        if (grp_digits < DigitSat) grp_digits++;
        grp_value = {grp_value[AccumW-5:0], nib[3:0]};
      end
    end
    if (is_last) begin
      len_ok = (grp_digits != 0) && (grp_digits <= DigitMax);
      r.ok   = !text_bad && (seen_dashes == DashExpected) && len_ok && (seen_chars <= CharLimit);
      r.hi   = r.ok ? word_hi : '0;
      r.lo   = r.ok ? (word_lo | WordW'(grp_value)) : '0;
      uuid_exp_q.push_back(r);
      seen_chars  = '0;
      seen_dashes = '0;
      grp_digits  = '0;
      text_bad    = 1'b0;
      grp_value   = '0;
      word_hi     = '0;
      word_lo     = '0;
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic add_lit(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // Append n random hex digits in random case
  task automatic add_hex(input int n);
    int v;
    for (int i = 0; i < n; i++) begin
      v = $urandom_range(0, 15);
      if (v < 10) text_buf.push_back(CharZero + 8'(v));
      else text_buf.push_back(($urandom_range(0, 1) ? CharLowA : CharUpA) + 8'(v - 10));
    end
  endtask

  task automatic add_uuid(input int l0, input int l1, input int l2, input int l3,
                          input int l4);
    add_hex(l0); text_buf.push_back(CharDash);
    add_hex(l1); text_buf.push_back(CharDash);
    add_hex(l2); text_buf.push_back(CharDash);
    add_hex(l3); text_buf.push_back(CharDash);
    add_hex(l4);
  endtask

  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? 16 : int'($urandom_range(1, 8));
  endfunction

  // Move the built string into the request queue, flagging its last character
  task automatic commit_text();
    for (int i = 0; i < text_buf.size(); i++)
      char_q.push_back('{ch: text_buf[i], is_last: (i == text_buf.size() - 1)});
    text_total += text_buf.size();
    text_buf.delete();
  endtask

  initial begin
    int         kind;
    int         pos;
    int         ng;
    int         lens[5];
    logic [7:0] near_hex[6];

    // Directed strings: extremes, lenient forms and every way to fail
    add_lit("00000000-0000-0000-0000-000000000000"); commit_text();
    add_lit("ffffffff-FFFF-ffff-FFFF-ffffffffffff"); commit_text();
    add_lit("12345678-9abc-DEF0-5678-9ABCdef01234"); commit_text();
    add_lit("1-2-3-4-5");                             commit_text();
    add_lit("0123456789abcdef-1-2-3-4");              commit_text();
    add_lit("1-2-3-4-fedcba9876543210");              commit_text();
    add_lit("0123456789abcdef0-1-2-3-4");             commit_text();
    add_lit("000000000-0000-0000-0000-000000000000"); commit_text();
    add_lit("1-2-3-4");                               commit_text();
    add_lit("1-2-3-4-5-6");                           commit_text();
    add_lit("1-2-3-4-5-6-7-8-9");                     commit_text();
    add_lit("1--3-4-5");                              commit_text();
    add_lit("-1-2-3-4");                              commit_text();
    add_lit("1-2-3-4-");                              commit_text();
    add_lit("7");                                     commit_text();
    add_lit("-");                                     commit_text();
    // Characters just outside the hex ranges
    near_hex = '{8'h2f, 8'h3a, 8'h40, 8'h47, 8'h60, 8'h67};
    foreach (near_hex[k]) begin
      add_lit("1-2-3-4-");
      text_buf.push_back(near_hex[k]);
      commit_text();
    end
    text_buf.push_back(8'h00); add_lit("-2-3-4-5");     commit_text();
    add_lit("1-2-3-4-5"); text_buf.push_back(8'h80);    commit_text();
    // Saturate the length and digit counters
    add_uuid(16, 16, 16, 16, 16);                       commit_text();
    add_uuid(20, 1, 1, 1, 1);                           commit_text();

    // Random strings: mostly well formed, the rest broken or noise
    while (text_total < TextTarget) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        add_uuid(8, 4, 4, 4, 12);
      end else if (kind < 70) begin
        add_uuid(pick_len(), pick_len(), pick_len(), pick_len(), pick_len());
      end else if (kind < 80) begin
        add_uuid(8, 4, 4, 4, 12);
        pos = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 2))
          0: text_buf[pos] = 8'($urandom_range(0, 255));
          1: text_buf.delete(pos);
          default: text_buf.insert(pos, CharDash);
        endcase
      end else if (kind < 88) begin
        foreach (lens[k]) lens[k] = $urandom_range(1, 4);
        lens[$urandom_range(0, 4)] = $urandom_range(0, 1) ? 0 : int'($urandom_range(17, 20));
        add_uuid(lens[0], lens[1], lens[2], lens[3], lens[4]);
      end else if (kind < 94) begin
        ng = $urandom_range(1, 7);
        for (int g = 0; g < ng; g++) begin
          if (g > 0) text_buf.push_back(CharDash);
          add_hex($urandom_range(1, 4));
        end
      end else begin
        ng = $urandom_range(1, 40);
        for (int i = 0; i < ng; i++) text_buf.push_back(8'($urandom_range(0, 255)));
      end
      commit_text();
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to go in and every result to come out, then drain
    while (char_q.size() != 0 || uuid_exp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_uuid_text_parser_core: PASS");
    end else begin
      $display("tb_uuid_text_parser_core: FAIL");
    end
    $finish;
  end

  // ------------------------------------------------------------------ driver
  // Offer the next request at the falling edge; hold a pending one unchanged
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || char_taken) begin
        char_taken = 1'b0;
        if (char_q.size() > 0 && (send_calm || $urandom_range(0, 99) >= IdlePct)) begin
          in_valid_i   <= 1'b1;
          text_char_i  <= char_q[0].ch;
          final_char_i <= char_q[0].is_last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Record an accepted request and advance the model
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      parse_char(text_char_i, final_char_i);
      void'(char_q.pop_front());
      char_taken = 1'b1;
      chars_sent++;
    end
  end

  // ----------------------------------------------------------------- monitor
  // Drive the output stall; once, hold off long enough to back up the input
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (!held_once && results_seen == HoldOffAt) begin
        held_once = 1'b1;
        hold_left = HoldOffCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !recv_calm && ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    uuid_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (uuid_exp_q.size() == 0) begin
        $error("unexpected result: parse_ok=%0b uuid=%016h%016h",
               parse_ok_o, uuid_high_o, uuid_low_o);
        errors++;
      end else begin
        want = uuid_exp_q.pop_front();
        if (parse_ok_o !== want.ok) begin
          $error("parse_ok: expected %0b, got %0b", want.ok, parse_ok_o);
          errors++;
        end
        if (uuid_high_o !== want.hi) begin
          $error("uuid_high: expected %016h, got %016h", want.hi, uuid_high_o);
          errors++;
        end
        if (uuid_low_o !== want.lo) begin
          $error("uuid_low: expected %016h, got %016h", want.lo, uuid_low_o);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  // End the run if neither channel completes a handshake for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("tb_uuid_text_parser_core: FAIL");
        $finish;
      end
    end
  end

endmodule

// ----- filelist.f -----
sv/utp_pkg.sv
sv/uuid_text_parser_core.sv
tb/tb_uuid_text_parser_core.sv
